/* rtl/hlg_pkg.sv */
// Shared types, constants and collision logic of the hexagonal lattice gas engine.
// Depends on nothing; the engine, the checker and the testbench import it.
`default_nettype none
package hlg_pkg;

	// Lattice size and the widths derived from it.
	localparam int GRID_COLS  = 256;
	localparam int GRID_ROWS  = 128;
	localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
	localparam int XW         = $clog2(GRID_COLS);
	localparam int YW         = $clog2(GRID_ROWS);
	localparam int AW         = $clog2(CELL_COUNT);

	// Choice generator: 16-bit Galois LFSR.
	localparam int               LFSR_W     = 16;
	localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_RESET = 16'd12345;

	// Request codes.
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_STEP  = 2'd2;

	// Cell kinds.
	localparam logic [1:0] KIND_FLUID = 2'd0;
	localparam logic [1:0] KIND_SOLID = 2'd1;
	localparam logic [1:0] KIND_SLIP  = 2'd2;

	// One stored cell: kind in the top two bits, particles below.
	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] occ;
	} cell_t;

	// Direction tables: the opposite direction and the mirror at a top or bottom edge.
	localparam logic [2:0] OPP_DIR    [6] = '{3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2};
	localparam logic [2:0] MIRROR_DIR [6] = '{3'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1};

	// Linear address of a cell, columns outer and rows inner.
	function automatic logic [AW-1:0] cell_addr(logic [XW-1:0] x, logic [YW-1:0] y);
		return AW'(int'(x) * GRID_ROWS + int'(y));
	endfunction

	// Rotate a six-bit direction mask left by r places, r below six.
	function automatic logic [5:0] rot6(logic [5:0] v, logic [2:0] r);
		return (v << r) | (v >> (3'd6 - r));
	endfunction

	// FHP collision of one cell's particles.
	function automatic logic [5:0] fhp_collide(logic [5:0] occ, logic choice);
		logic [5:0] r;
		logic [2:0] n;
		logic       found;
		logic       axis1;
		r     = occ;
		n     = '0;
		found = 1'b0;
		axis1 = 1'b0;
		for (int i = 0; i < 6; i++) begin
			n = n + 3'(occ[i]);
		end
		if (n == 3'd2) begin
			// A head-on pair turns one way or the other.
			for (int d = 0; d < 3; d++) begin
				if (!found && occ[d] && occ[d+3]) begin
					found = 1'b1;
					r = occ & ~rot6(6'b001001, 3'(d));
					r = r | (choice ? rot6(6'b001001, 3'(d + 2))
					                : rot6(6'b001001, 3'(d + 1)));
				end
			end
		end else if (n == 3'd3) begin
			// Symmetric triples swap; a pair with a spectator turns away from it.
			if (occ == 6'h15) begin
				r = 6'h2A;
			end else if (occ == 6'h2A) begin
				r = 6'h15;
			end else begin
				for (int d = 0; d < 3; d++) begin
					if (!found && occ[d] && occ[d+3]) begin
						found = 1'b1;
						axis1 = |(occ & rot6(6'b001001, 3'(d + 1)));
						r = occ & ~rot6(6'b001001, 3'(d));
						r = r | (axis1 ? rot6(6'b001001, 3'(d + 2))
						               : rot6(6'b001001, 3'(d + 1)));
					end
				end
			end
		end else if (n == 3'd4) begin
			// A head-on hole pair turns like a particle pair.
			for (int d = 0; d < 3; d++) begin
				if (!found && !occ[d] && !occ[d+3]) begin
					found = 1'b1;
					r = occ | rot6(6'b001001, 3'(d));
					r = r & ~(choice ? rot6(6'b001001, 3'(d + 2))
					                 : rot6(6'b001001, 3'(d + 1)));
				end
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/hlg_if.sv */
// Request and reply channels of the lattice gas engine, valid/ready handshake.
// Depends on nothing.
`default_nettype none
interface hlg_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] cell_x;
	logic [6:0] cell_y;
	logic [5:0] occupancy;
	logic [1:0] cell_kind;
	modport source (output valid, req_type, cell_x, cell_y, occupancy, cell_kind, input ready);
	modport sink   (input valid, req_type, cell_x, cell_y, occupancy, cell_kind, output ready);
endinterface

interface hlg_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] reply_kind;
	logic [5:0] read_occupancy;
	logic [1:0] read_kind;
	modport source (output valid, reply_kind, read_occupancy, read_kind, input ready);
	modport sink   (input valid, reply_kind, read_occupancy, read_kind, output ready);
endinterface
`default_nettype wire

/* rtl/hlg_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none
module hlg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/hex_lattice_gas_step_engine_unit.sv */
// Hexagonal lattice gas engine: a write, read or step request yields exactly one reply
// request. A step takes two passes: collision reads every cell once from the lattice
// store, then streaming gathers each cell from itself and its six neighbours through the
// single read port of the collided store. One request is worked on at a time; a new one
// is taken as soon as the previous reply is in the output register.
// Both stores are undefined after reset and every cell must be written before a step.
// Depends on hlg_pkg, hlg_if and hlg_ram.
`default_nettype none
module hex_lattice_gas_step_engine_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	hlg_req_if.sink                        req,
	hlg_rsp_if.source                      rsp,
	input  wire logic                      cfg_wr_en,
	input  wire logic [hlg_pkg::LFSR_W-1:0] cfg_wr_data
);
	import hlg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD_WAIT, ST_COLL, ST_COLL_END, ST_STRM, ST_STRM_END, ST_REPLY
	} state_t;

	state_t            state_q;
	logic [XW-1:0]     x_q;
	logic [YW-1:0]     y_q;
	logic [2:0]        k_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [1:0]        reply_kind_q;
	logic              rd_inside_q;
	logic [5:0]        rd_occ_q;
	logic [1:0]        rd_kind_q;
	logic              rsp_valid_q;
	logic [1:0]        rsp_kind_q;
	logic [5:0]        rsp_occ_q;
	logic [1:0]        rsp_rkind_q;

	logic              coll_v_s1;
	logic [AW-1:0]     coll_addr_s1;
	logic              strm_v_s1;
	logic [2:0]        strm_k_s1;
	logic              strm_oob_s1;
	logic [AW-1:0]     strm_addr_s1;
	cell_t             self_q;
	logic [5:0]        acc_q;

	logic              l_wr_en, l_rd_en, c_wr_en, c_rd_en;
	logic [AW-1:0]     l_wr_addr, l_rd_addr, c_wr_addr, c_rd_addr;
	cell_t             l_wr_data, l_rd_data, c_wr_data, c_rd_data;

	logic              req_acc;
	logic              req_inside;
	logic [AW-1:0]     req_addr;
	logic [1:0]        wr_kind;
	logic              last_cell;
	logic              coll_solid;
	logic              strm_last;
	logic [2:0]        nb_dir;
	logic [2:0]        s1_dir;
	logic              nb_oob;
	logic [XW-1:0]     nb_x;
	logic [YW-1:0]     nb_y;
	logic [5:0]        acc_next;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.reply_kind     = rsp_kind_q;
	assign rsp.read_occupancy = rsp_occ_q;
	assign rsp.read_kind      = rsp_rkind_q;

	// Request decode: place in the lattice and the kind a write stores.
	assign req_inside = (int'(req.cell_x) < GRID_COLS) && (int'(req.cell_y) < GRID_ROWS);
	assign req_addr   = cell_addr(XW'(req.cell_x), YW'(req.cell_y));
	assign wr_kind    = (req.cell_kind == KIND_FLUID || req.cell_kind == KIND_SOLID)
	                    ? req.cell_kind : KIND_SLIP;
	assign last_cell  = (x_q == XW'(GRID_COLS - 1)) && (y_q == YW'(GRID_ROWS - 1));
	assign strm_last  = last_cell && (k_q == 3'd6);

	// Neighbour of the current cell in the direction being gathered.
	assign nb_dir = k_q - 3'd1;
	always_comb begin
		nb_x   = x_q;
		nb_y   = y_q;
		nb_oob = 1'b0;
		case (nb_dir)
			3'd0: nb_x = (x_q == XW'(GRID_COLS - 1)) ? '0 : x_q + 1'b1;
			3'd3: nb_x = (x_q == '0) ? XW'(GRID_COLS - 1) : x_q - 1'b1;
			3'd1, 3'd5: begin
				if (y_q[0]) begin
					nb_x = (x_q == XW'(GRID_COLS - 1)) ? '0 : x_q + 1'b1;
				end
			end
			3'd2, 3'd4: begin
				if (!y_q[0]) begin
					nb_x = (x_q == '0) ? XW'(GRID_COLS - 1) : x_q - 1'b1;
				end
			end
			default: nb_x = x_q;
		endcase
		case (nb_dir)
			3'd1, 3'd2: begin
				nb_oob = (y_q == YW'(GRID_ROWS - 1));
				nb_y   = y_q + 1'b1;
			end
			3'd4, 3'd5: begin
				nb_oob = (y_q == '0);
				nb_y   = y_q - 1'b1;
			end
			default: nb_y = y_q;
		endcase
	end

	// Collision of the cell read in the previous cycle.
	assign coll_solid = (l_rd_data.kind == KIND_SOLID);

	// Streaming: fold one neighbour into the gathered particles.
	assign s1_dir = strm_k_s1 - 3'd1;
	always_comb begin
		acc_next = acc_q;
		if (strm_oob_s1) begin
			if (self_q.occ[s1_dir]) begin
				acc_next[MIRROR_DIR[s1_dir]] = 1'b1;
			end
		end else if (c_rd_data.kind == KIND_SOLID) begin
			if (self_q.occ[s1_dir]) begin
				acc_next[OPP_DIR[s1_dir]] = 1'b1;
			end
		end else if (c_rd_data.occ[OPP_DIR[s1_dir]]) begin
			acc_next[OPP_DIR[s1_dir]] = 1'b1;
		end
	end

	// Port selection of the two stores.
	always_comb begin
		l_wr_en   = 1'b0;
		l_wr_addr = req_addr;
		l_wr_data = '{kind: wr_kind, occ: (wr_kind == KIND_SOLID) ? 6'd0 : req.occupancy};
		l_rd_en   = 1'b0;
		l_rd_addr = req_addr;
		if (req_acc && req.req_type == REQ_WRITE && req_inside) begin
			l_wr_en = 1'b1;
		end
		if (strm_v_s1 && strm_k_s1 == 3'd6) begin
			l_wr_en   = 1'b1;
			l_wr_addr = strm_addr_s1;
			l_wr_data = '{kind: self_q.kind,
			              occ: (self_q.kind == KIND_SOLID) ? 6'd0 : acc_next};
		end
		if (req_acc && req.req_type == REQ_READ) begin
			l_rd_en = 1'b1;
		end
		if (state_q == ST_COLL) begin
			l_rd_en   = 1'b1;
			l_rd_addr = cell_addr(x_q, y_q);
		end
		c_wr_en   = coll_v_s1;
		c_wr_addr = coll_addr_s1;
		c_wr_data = '{kind: l_rd_data.kind,
		              occ: coll_solid ? 6'd0 : fhp_collide(l_rd_data.occ, lfsr_q[0])};
		c_rd_en   = (state_q == ST_STRM);
		c_rd_addr = (k_q == 3'd0) ? cell_addr(x_q, y_q) : cell_addr(nb_x, nb_y);
	end

	hlg_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_lattice_ram (
		.clk    (clk),
		.wr_en  (l_wr_en),
		.wr_addr(l_wr_addr),
		.wr_data(l_wr_data),
		.rd_en  (l_rd_en),
		.rd_addr(l_rd_addr),
		.rd_data(l_rd_data)
	);

	hlg_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_collided_ram (
		.clk    (clk),
		.wr_en  (c_wr_en),
		.wr_addr(c_wr_addr),
		.wr_data(c_wr_data),
		.rd_en  (c_rd_en),
		.rd_addr(c_rd_addr),
		.rd_data(c_rd_data)
	);

	// Sequencer, pipeline registers and reply register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			x_q          <= '0;
			y_q          <= '0;
			k_q          <= '0;
			lfsr_q       <= LFSR_RESET;
			rsp_valid_q  <= 1'b0;
			rsp_kind_q   <= REQ_WRITE;
			rsp_occ_q    <= '0;
			rsp_rkind_q  <= '0;
			coll_v_s1    <= 1'b0;
			coll_addr_s1 <= '0;
			strm_v_s1    <= 1'b0;
			strm_k_s1    <= '0;
			strm_oob_s1  <= 1'b0;
			strm_addr_s1 <= '0;
			self_q       <= '0;
			acc_q        <= '0;
			reply_kind_q <= REQ_WRITE;
			rd_inside_q  <= 1'b0;
			rd_occ_q     <= '0;
			rd_kind_q    <= '0;
		end else begin
			coll_v_s1 <= 1'b0;
			strm_v_s1 <= 1'b0;
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			// Collision write-back draws a choice bit for each non-solid cell.
			if (coll_v_s1 && !coll_solid) begin
				lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : '0);
			end

			// Streaming gather: the cell itself arrives first, then its neighbours.
			if (strm_v_s1) begin
				if (strm_k_s1 == 3'd0) begin
					self_q <= c_rd_data;
					acc_q  <= '0;
				end else begin
					acc_q <= acc_next;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						reply_kind_q <= req.req_type;
						rd_occ_q     <= '0;
						rd_kind_q    <= '0;
						rd_inside_q  <= req_inside;
						x_q          <= '0;
						y_q          <= '0;
						k_q          <= '0;
						case (req.req_type)
							REQ_WRITE: state_q <= ST_REPLY;
							REQ_READ:  state_q <= ST_RD_WAIT;
							REQ_STEP:  state_q <= ST_COLL;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RD_WAIT: begin
					rd_occ_q  <= rd_inside_q ? l_rd_data.occ : 6'd0;
					rd_kind_q <= rd_inside_q ? l_rd_data.kind : 2'd0;
					state_q   <= ST_REPLY;
				end
				ST_COLL: begin
					coll_v_s1    <= 1'b1;
					coll_addr_s1 <= cell_addr(x_q, y_q);
					if (y_q == YW'(GRID_ROWS - 1)) begin
						y_q <= '0;
						x_q <= x_q + 1'b1;
					end else begin
						y_q <= y_q + 1'b1;
					end
					if (last_cell) begin
						x_q     <= '0;
						y_q     <= '0;
						state_q <= ST_COLL_END;
					end
				end
				ST_COLL_END: begin
					k_q     <= '0;
					state_q <= ST_STRM;
				end
				ST_STRM: begin
					strm_v_s1    <= 1'b1;
					strm_k_s1    <= k_q;
					strm_oob_s1  <= (k_q != 3'd0) && nb_oob;
					strm_addr_s1 <= cell_addr(x_q, y_q);
					if (k_q == 3'd6) begin
						k_q <= '0;
						if (y_q == YW'(GRID_ROWS - 1)) begin
							y_q <= '0;
							x_q <= x_q + 1'b1;
						end else begin
							y_q <= y_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
					if (strm_last) begin
						state_q <= ST_STRM_END;
					end
				end
				ST_STRM_END: begin
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_kind_q  <= reply_kind_q;
						rsp_occ_q   <= rd_occ_q;
						rsp_rkind_q <= rd_kind_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// A seed write reloads the choice generator.
			if (cfg_wr_en) begin
				lfsr_q <= cfg_wr_data;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/hlg_checker.sv */
// Port-level checks of the lattice gas engine, bound to its top level.
// Depends on hlg_pkg and the top level hex_lattice_gas_step_engine_unit.
`default_nettype none
module hlg_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic [1:0] req_type,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] reply_kind,
	input wire logic [5:0] read_occupancy,
	input wire logic [1:0] read_kind
);
	import hlg_pkg::*;

	// A stalled reply stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("reply withdrawn while stalled");

	// A stalled reply keeps its kind.
	a_rsp_kind_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(reply_kind))
		else $error("reply kind changed while stalled");

	// A request that is served keeps the block busy in the following cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready &&
		(req_type == REQ_WRITE || req_type == REQ_READ || req_type == REQ_STEP)
		|=> !req_ready)
		else $error("request taken while the previous one is in flight");

	// Only a read reply carries cell data.
	a_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && reply_kind != REQ_READ |-> read_occupancy == '0 && read_kind == '0)
		else $error("cell data on a reply that is not a read");

endmodule

bind hex_lattice_gas_step_engine_unit hlg_checker u_hlg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_type      (req.req_type),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.reply_kind    (rsp.reply_kind),
	.read_occupancy(rsp.read_occupancy),
	.read_kind     (rsp.read_kind)
);
`default_nettype wire

/* tb/hex_lattice_gas_step_engine_unit_tb.sv */
// Self-checking testbench of the hexagonal lattice gas engine: cell writes, reads and full steps.
// Depends on hlg_pkg, hlg_if and the engine RTL; the lattice predictor lives in a class below.
`default_nettype none
module hex_lattice_gas_step_engine_unit_tb;
	import hlg_pkg::*;

	// Request code that the engine ignores.
	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam logic [1:0] KIND_ODD    = 2'd3;

	typedef struct {
		logic [1:0] reply;
		logic [5:0] occ;
		logic [1:0] kind;
	} reply_t;

	// Lattice predictor and reply store.
	class lattice_scoreboard;
		logic [5:0]  occ_map  [CELL_COUNT];
		logic [1:0]  kind_map [CELL_COUNT];
		logic [15:0] chooser;
		reply_t      replies [$];
		int          errors;
		int          checked;

		function new();
			chooser = LFSR_RESET;
			errors  = 0;
			checked = 0;
		endfunction

		function void load_seed(logic [15:0] v);
			chooser = v;
		endfunction

		function logic [5:0] axis(int d);
			return (6'b1 << (d % 6)) | (6'b1 << ((d + 3) % 6));
		endfunction

		// Collision rules of one cell.
		function logic [5:0] scatter(logic [5:0] o, logic ch);
			logic [5:0] r;
			int         n;
			logic       side;
			r = o;
			n = $countones(o);
			if (n == 2) begin
				for (int d = 0; d < 3; d++) begin
					if (o[d] && o[d+3]) begin
						r = (o & ~axis(d)) | (ch ? axis(d + 2) : axis(d + 1));
						break;
					end
				end
			end else if (n == 3) begin
				if (o == 6'h15) begin
					r = 6'h2A;
				end else if (o == 6'h2A) begin
					r = 6'h15;
				end else begin
					for (int d = 0; d < 3; d++) begin
						if (o[d] && o[d+3]) begin
							side = o[(d+1)%6] || o[(d+4)%6];
							r = (o & ~axis(d)) | (side ? axis(d + 2) : axis(d + 1));
							break;
						end
					end
				end
			end else if (n == 4) begin
				for (int d = 0; d < 3; d++) begin
					if (!o[d] && !o[d+3]) begin
						r = (o | axis(d)) & ~(ch ? axis(d + 2) : axis(d + 1));
						break;
					end
				end
			end
			return r;
		endfunction

		// One full step: collide every non-solid cell, then stream.
		function void advance();
			logic [5:0] hit [CELL_COUNT];
			int         row_go [6];
			int         mirror [6];
			int         idx, nx, ny, dx, par, dst;
			logic       ch;
			row_go = '{0, 1, 1, 0, -1, -1};
			mirror = '{0, 5, 4, 3, 2, 1};
			for (int x = 0; x < GRID_COLS; x++) begin
				for (int y = 0; y < GRID_ROWS; y++) begin
					idx = x * GRID_ROWS + y;
					if (kind_map[idx] == KIND_SOLID) begin
						hit[idx] = '0;
					end else begin
						ch = chooser[0];
						chooser = chooser >> 1;
						if (ch) chooser ^= LFSR_MASK;
						hit[idx] = scatter(occ_map[idx], ch);
					end
					occ_map[idx] = '0;
				end
			end
			for (int x = 0; x < GRID_COLS; x++) begin
				for (int y = 0; y < GRID_ROWS; y++) begin
					idx = x * GRID_ROWS + y;
					par = y & 1;
					if (kind_map[idx] == KIND_SOLID) continue;
					for (int d = 0; d < 6; d++) begin
						if (!hit[idx][d]) continue;
						case (d)
							0: dx = 1;
							3: dx = -1;
							1, 5: dx = par;
							default: dx = par - 1;
						endcase
						nx = (x + dx + GRID_COLS) % GRID_COLS;
						ny = y + row_go[d];
						if (ny < 0 || ny >= GRID_ROWS) begin
							occ_map[idx][mirror[d]] = 1'b1;
						end else begin
							dst = nx * GRID_ROWS + ny;
							if (kind_map[dst] == KIND_SOLID)
								occ_map[idx][(d+3)%6] = 1'b1;
							else
								occ_map[dst][d] = 1'b1;
						end
					end
				end
			end
		endfunction

		// Note an accepted request and queue the reply it should produce.
		function void note_request(logic [1:0] rt, logic [7:0] x, logic [6:0] y,
		                           logic [5:0] o, logic [1:0] k);
			reply_t e;
			int     idx;
			idx    = int'(x) * GRID_ROWS + int'(y);
			e.reply = rt;
			e.occ   = '0;
			e.kind  = '0;
			case (rt)
				REQ_WRITE: begin
					if (k == KIND_ODD) k = KIND_SLIP;
					kind_map[idx] = k;
					occ_map[idx]  = (k == KIND_SOLID) ? 6'd0 : o;
				end
				REQ_READ: begin
					e.occ  = occ_map[idx];
					e.kind = kind_map[idx];
				end
				REQ_STEP: advance();
				default: return;
			endcase
			replies.push_back(e);
		endfunction

		// Compare one reply with the oldest expectation.
		function void check_reply(logic [1:0] rk, logic [5:0] o, logic [1:0] k);
			reply_t e;
			if (replies.size() == 0) begin
				$display("%0t: unexpected reply kind=%0d occ=%h cell kind=%0d", $time, rk, o, k);
				errors++;
				return;
			end
			e = replies.pop_front();
			checked++;
			if (rk !== e.reply) begin
				$display("%0t: reply kind expected %0d actual %0d", $time, e.reply, rk);
				errors++;
			end
			if (o !== e.occ) begin
				$display("%0t: read occupancy expected %h actual %h", $time, e.occ, o);
				errors++;
			end
			if (k !== e.kind) begin
				$display("%0t: read kind expected %0d actual %0d", $time, e.kind, k);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	hlg_req_if   req_ch ();
	hlg_rsp_if   rsp_ch ();

	lattice_scoreboard board;
	int burst_left;
	int n_steps;
	int n_reads;
	int n_writes;

	hex_lattice_gas_step_engine_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit, well above three steps, a full fill and every stall.
	initial begin
		#(20 * 6000000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Reply side: check accepted replies, stall in changing modes.
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				board.check_reply(rsp_ch.reply_kind, rsp_ch.read_occupancy, rsp_ch.read_kind);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(20, 300);
			end
			left--;
			case (mode)
				0: rsp_ch.ready <= arst_n;
				1: rsp_ch.ready <= arst_n && ($urandom_range(0, 3) != 0);
				default: rsp_ch.ready <= arst_n && ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	// Send one request in bursts with random gaps; valid stays high within a burst.
	task automatic issue(logic [1:0] rt, logic [7:0] x, logic [6:0] y,
	                     logic [5:0] o, logic [1:0] k);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= rt;
		req_ch.cell_x    <= x;
		req_ch.cell_y    <= y;
		req_ch.occupancy <= o;
		req_ch.cell_kind <= k;
		do @(posedge clk); while (!req_ch.ready);
		board.note_request(rt, x, y, o, k);
		case (rt)
			REQ_STEP: n_steps++;
			REQ_READ: n_reads++;
			REQ_WRITE: n_writes++;
			default: ;
		endcase
	endtask

	// Drop valid and wait until every reply is in.
	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.replies.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Load a new seed while the engine is idle.
	task automatic set_seed(logic [15:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.load_seed(v);
	endtask

	function automatic logic [1:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 82) return KIND_FLUID;
		if (r < 92) return KIND_SOLID;
		if (r < 97) return KIND_SLIP;
		return KIND_ODD;
	endfunction

	// Mixed writes, reads and ignored requests with one step in the middle.
	task automatic random_phase(int count, bit hold_off);
		int r;
		for (int i = 0; i < count; i++) begin
			if (hold_off && i == 10) drain();
			if (i == count / 2) begin
				issue(REQ_STEP, 8'($urandom), 7'($urandom), 6'($urandom), 2'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40)
					issue(REQ_WRITE, 8'($urandom), 7'($urandom), 6'($urandom), pick_kind());
				else if (r < 94)
					issue(REQ_READ, 8'($urandom), 7'($urandom), 6'($urandom), 2'($urandom));
				else
					issue(REQ_IGNORED, 8'($urandom), 7'($urandom), 6'($urandom),
					      2'($urandom));
			end
		end
	endtask

	// Main sequence.
	initial begin
		int limit;
		board            = new();
		burst_left       = 0;
		n_steps          = 0;
		n_reads          = 0;
		n_writes         = 0;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_WRITE;
		req_ch.cell_x    = '0;
		req_ch.cell_y    = '0;
		req_ch.occupancy = '0;
		req_ch.cell_kind = KIND_FLUID;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: corners, every kind, solid with particles, odd kind, ignored request.
		issue(REQ_WRITE, 8'd0, 7'd0, 6'h3F, KIND_FLUID);
		issue(REQ_WRITE, 8'd255, 7'd127, 6'h15, KIND_SLIP);
		issue(REQ_WRITE, 8'd255, 7'd0, 6'h2A, KIND_ODD);
		issue(REQ_WRITE, 8'd0, 7'd127, 6'h3F, KIND_SOLID);
		issue(REQ_WRITE, 8'd128, 7'd64, 6'h09, KIND_FLUID);
		issue(REQ_READ, 8'd0, 7'd0, 6'h00, KIND_FLUID);
		issue(REQ_READ, 8'd255, 7'd127, 6'h3F, KIND_ODD);
		issue(REQ_READ, 8'd255, 7'd0, 6'h00, KIND_FLUID);
		issue(REQ_READ, 8'd0, 7'd127, 6'h00, KIND_FLUID);
		issue(REQ_IGNORED, 8'd128, 7'd64, 6'h3F, KIND_SOLID);
		issue(REQ_READ, 8'd128, 7'd64, 6'h00, KIND_FLUID);

		// Fill the whole lattice so that steps are well defined.
		for (int x = 0; x < GRID_COLS; x++)
			for (int y = 0; y < GRID_ROWS; y++)
				issue(REQ_WRITE, 8'(x), 7'(y), 6'($urandom), pick_kind());

		// Directed step with the reset seed, then corner reads.
		issue(REQ_STEP, 8'd0, 7'd0, 6'h00, KIND_FLUID);
		issue(REQ_READ, 8'd0, 7'd0, 6'h00, KIND_FLUID);
		issue(REQ_READ, 8'd255, 7'd127, 6'h00, KIND_FLUID);
		issue(REQ_READ, 8'd0, 7'd127, 6'h00, KIND_FLUID);

		// Random phases under the extreme seeds.
		set_seed(16'hFFFF);
		random_phase(50, 1'b1);
		set_seed(16'h0001);
		random_phase(50, 1'b0);

		// Wait for the last replies, with a limit.
		req_ch.valid <= 1'b0;
		limit = 0;
		while (board.replies.size() > 0 && limit < 2000000) begin
			@(posedge clk);
			limit++;
		end
		repeat (50) @(posedge clk);
		if (board.replies.size() > 0) begin
			$display("%0t: %0d replies never arrived", $time, board.replies.size());
			board.errors++;
		end

		$display("Covered %0d writes, %0d reads and %0d lattice steps; %0d replies checked.",
		         n_writes, n_reads, n_steps, board.checked);
		if (board.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
rtl/hlg_pkg.sv
rtl/hlg_if.sv
rtl/hlg_ram.sv
rtl/hex_lattice_gas_step_engine_unit.sv
rtl/hlg_checker.sv
tb/hex_lattice_gas_step_engine_unit_tb.sv
